### src/rkct_pkg.sv
// Shared types and constants for the reference-counted key table.
// Used by the interfaces, controller, datapath, top level and checker.
package rkct_pkg;

	// Operation codes carried by a request word
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		ST_HIT          = 3'd0,
		ST_INSERTED     = 3'd1,
		ST_NOT_INSERTED = 3'd2,
		ST_DECREMENTED  = 3'd3,
		ST_FREED        = 3'd4,
		ST_REL_MISS     = 3'd5
	} status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming request word
		logic match;    // compare key against all used entries
		logic read;     // encode hit/free and read the entry stores
		logic update;   // modify the entry and load the result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_busy; // result register full and not being taken
	} sts_t;

endpackage

### src/rkct_if.sv
// Request and response channel interfaces for the key table.
// Depends on rkct_pkg for the status type.
interface rkct_req_if #(
	parameter int HANDLE_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic [63:0]            key_high;
	logic [63:0]            key_low;
	logic                   load_ok;
	logic [HANDLE_BITS-1:0] new_handle;

	modport source (output valid, operation, key_high, key_low, load_ok, new_handle,
		input ready);
	modport sink (input valid, operation, key_high, key_low, load_ok, new_handle,
		output ready);
endinterface

interface rkct_rsp_if #(
	parameter int SLOT_BITS   = 5,
	parameter int COUNT_BITS  = 16,
	parameter int HANDLE_BITS = 32
);
	logic                   valid;
	logic                   ready;
	rkct_pkg::status_t      status;
	logic [SLOT_BITS-1:0]   slot;
	logic [COUNT_BITS-1:0]  count;
	logic [HANDLE_BITS-1:0] handle;

	modport source (output valid, status, slot, count, handle, input ready);
	modport sink (input valid, status, slot, count, handle, output ready);
endinterface

### src/rkct_ctrl.sv
// Sequencing controller for the key table: one request word at a time.
// Depends on rkct_pkg for the command and status structs.
module rkct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rkct_pkg::sts_t sts,
	output rkct_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_READ,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   fire;

	assign fire      = req_valid && ready_q;
	assign req_ready = ready_q;

	// command decode from the current state
	assign cmd.capture = fire;
	assign cmd.match   = (state_q == S_MATCH);
	assign cmd.read    = (state_q == S_READ);
	assign cmd.update  = (state_q == S_UPDATE) && !sts.out_busy;

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						state_q <= S_MATCH;
						ready_q <= 1'b0;
					end
				end
				S_MATCH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// hold until the result register can take the word
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

### src/rkct_dp.sv
// Datapath of the key table: key registers, free map, handle and count
// stores, lookup and result register. Depends on rkct_pkg.
module rkct_dp #(
	parameter int ENTRIES     = 24,
	parameter int HANDLE_BITS = 32,
	parameter int COUNT_BITS  = 16,
	parameter int SLOT_BITS   = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rkct_pkg::cmd_t         cmd,
	output rkct_pkg::sts_t         sts,
	// request word
	input  logic                   operation,
	input  logic [63:0]            key_high,
	input  logic [63:0]            key_low,
	input  logic                   load_ok,
	input  logic [HANDLE_BITS-1:0] new_handle,
	// response word
	output logic                   out_valid,
	input  logic                   out_ready,
	output rkct_pkg::status_t      status,
	output logic [SLOT_BITS-1:0]   slot,
	output logic [COUNT_BITS-1:0]  count,
	output logic [HANDLE_BITS-1:0] handle
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	// captured request
	logic                   op_q;
	logic [63:0]            key_hi_q;
	logic [63:0]            key_lo_q;
	logic                   load_ok_q;
	logic [HANDLE_BITS-1:0] nh_q;

	// entry state: keys compared in parallel, so held in flops
	logic [63:0]            key_hi_mem [ENTRIES];
	logic [63:0]            key_lo_mem [ENTRIES];
	logic [ENTRIES-1:0]     free_q;
	// handle and count stores: one read and one write port each
	logic [HANDLE_BITS-1:0] hnd_mem [ENTRIES];
	logic [COUNT_BITS-1:0]  cnt_mem [ENTRIES];

	logic [ENTRIES-1:0]     match_c;
	logic [ENTRIES-1:0]     match_q;
	logic                   hit_c;
	logic [SLOT_BITS-1:0]   hit_idx_c;
	logic                   free_found_c;
	logic [SLOT_BITS-1:0]   free_idx_c;
	logic                   hit_q;
	logic [SLOT_BITS-1:0]   hit_idx_q;
	logic                   free_found_q;
	logic [SLOT_BITS-1:0]   free_idx_q;
	logic [HANDLE_BITS-1:0] hnd_rd_q;
	logic [COUNT_BITS-1:0]  cnt_rd_q;

	// update decisions
	logic                   do_insert;
	logic                   do_free;
	logic                   cnt_we;
	logic [SLOT_BITS-1:0]   cnt_wa;
	logic [COUNT_BITS-1:0]  cnt_wd;
	rkct_pkg::status_t      res_status;
	logic [SLOT_BITS-1:0]   res_slot;
	logic [COUNT_BITS-1:0]  res_count;
	logic [HANDLE_BITS-1:0] res_handle;

	// result register
	logic                   out_valid_q;
	rkct_pkg::status_t      status_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// capture request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			key_hi_q  <= key_high;
			key_lo_q  <= key_low;
			load_ok_q <= load_ok;
			nh_q      <= new_handle;
		end
	end

	// parallel key compare; free entries never match
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_c[i] = !free_q[i] && (key_hi_mem[i] == key_hi_q) &&
				(key_lo_mem[i] == key_lo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			match_q <= match_c;
		end
	end

	// lowest matching entry and lowest free entry
	always_comb begin
		hit_c        = 1'b0;
		hit_idx_c    = '0;
		free_found_c = 1'b0;
		free_idx_c   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_c     = 1'b1;
				hit_idx_c = SLOT_BITS'(i);
			end
			if (free_q[i]) begin
				free_found_c = 1'b1;
				free_idx_c   = SLOT_BITS'(i);
			end
		end
	end

	// encoded indices and registered store read at the hit entry
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			hit_q        <= hit_c;
			hit_idx_q    <= hit_idx_c;
			free_found_q <= free_found_c;
			free_idx_q   <= free_idx_c;
			hnd_rd_q     <= hnd_mem[hit_idx_c];
			cnt_rd_q     <= cnt_mem[hit_idx_c];
		end
	end

	// work out the entry update and the result word
	always_comb begin
		do_insert  = 1'b0;
		do_free    = 1'b0;
		cnt_we     = 1'b0;
		cnt_wa     = hit_idx_q;
		cnt_wd     = '0;
		res_status = rkct_pkg::ST_NOT_INSERTED;
		res_slot   = '0;
		res_count  = '0;
		res_handle = '0;
		priority if (op_q == rkct_pkg::OP_ACQUIRE && hit_q) begin
			// hit: bump the count, saturating
			cnt_we     = 1'b1;
			cnt_wd     = (cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + CNT_ONE;
			res_status = rkct_pkg::ST_HIT;
			res_slot   = hit_idx_q;
			res_count  = cnt_wd;
			res_handle = hnd_rd_q;
		end else if (op_q == rkct_pkg::OP_ACQUIRE) begin
			if (load_ok_q && free_found_q) begin
				do_insert  = 1'b1;
				cnt_we     = 1'b1;
				cnt_wa     = free_idx_q;
				cnt_wd     = CNT_ONE;
				res_status = rkct_pkg::ST_INSERTED;
				res_slot   = free_idx_q;
				res_count  = CNT_ONE;
			end
		end else if (hit_q) begin
			// release of a used entry
			cnt_we   = 1'b1;
			res_slot = hit_idx_q;
			if (cnt_rd_q > CNT_ONE) begin
				cnt_wd     = cnt_rd_q - CNT_ONE;
				res_status = rkct_pkg::ST_DECREMENTED;
				res_count  = cnt_wd;
			end else begin
				do_free    = 1'b1;
				res_status = rkct_pkg::ST_FREED;
				res_handle = hnd_rd_q;
			end
		end else begin
			res_status = rkct_pkg::ST_REL_MISS;
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (cnt_we) begin
				cnt_mem[cnt_wa] <= cnt_wd;
			end
			if (do_insert) begin
				hnd_mem[free_idx_q]    <= nh_q;
				key_hi_mem[free_idx_q] <= key_hi_q;
				key_lo_mem[free_idx_q] <= key_lo_q;
			end
		end
	end

	// free map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (cmd.update) begin
			if (do_insert) begin
				free_q[free_idx_q] <= 1'b0;
			end
			if (do_free) begin
				free_q[hit_idx_q] <= 1'b1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			count_q  <= res_count;
			handle_q <= res_handle;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign count        = count_q;
	assign handle       = handle_q;

endmodule

### src/refcount_key_cache_table.sv
// Top level of the reference-counted key table: controller plus datapath.
// Depends on rkct_pkg, rkct_if, rkct_ctrl and rkct_dp.
//
//  channel | dir | word contents
//  --------+-----+------------------------------------------------------
//  req     | in  | operation, key_high, key_low, load_ok, new_handle
//  rsp     | out | status, slot, count, handle
//
// Each request word goes through these steps from acceptance to its result word:
// accept, key compare over all entries, hit/free encode with the store read,
// then update and result load. The next word is accepted in the cycle after
// the update, so only one word is in flight at a time.
// A stalled result holds the update step until the result register drains.
// Reset clears the free map (all entries free) and the control state.
module refcount_key_cache_table #(
	parameter int ENTRIES     = 24,
	parameter int HANDLE_BITS = 32,
	parameter int COUNT_BITS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	rkct_req_if.sink   req,
	rkct_rsp_if.source rsp
);

	localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	rkct_pkg::cmd_t cmd;
	rkct_pkg::sts_t sts;

	rkct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rkct_dp #(
		.ENTRIES     (ENTRIES),
		.HANDLE_BITS (HANDLE_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.SLOT_BITS   (SLOT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (req.operation),
		.key_high   (req.key_high),
		.key_low    (req.key_low),
		.load_ok    (req.load_ok),
		.new_handle (req.new_handle),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.status     (rsp.status),
		.slot       (rsp.slot),
		.count      (rsp.count),
		.handle     (rsp.handle)
	);

endmodule

### src/rkct_checker.sv
// Port-level checker for the key table, bound to the top level.
// Depends on rkct_pkg for status codes.
module rkct_checker #(
	parameter int SLOT_BITS   = 5,
	parameter int COUNT_BITS  = 16,
	parameter int HANDLE_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input rkct_pkg::status_t      status,
	input logic [SLOT_BITS-1:0]   slot,
	input logic [COUNT_BITS-1:0]  count,
	input logic [HANDLE_BITS-1:0] handle
);

	// a stalled result word holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot) &&
			$stable(count) && $stable(handle))
		else $error("result word changed while stalled");

	// only one word in flight: acceptance drops ready
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// an insert reports count one and no handle
	a_insert_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == rkct_pkg::ST_INSERTED |->
			count == COUNT_BITS'(1) && handle == '0)
		else $error("insert result fields wrong");

	// misses report no entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == rkct_pkg::ST_NOT_INSERTED ||
			status == rkct_pkg::ST_REL_MISS) |->
			slot == '0 && count == '0 && handle == '0)
		else $error("miss result carries entry data");

endmodule

bind refcount_key_cache_table rkct_checker #(
	.SLOT_BITS   (SLOT_BITS),
	.COUNT_BITS  (COUNT_BITS),
	.HANDLE_BITS (HANDLE_BITS)
) u_rkct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.slot      (rsp.slot),
	.count     (rsp.count),
	.handle    (rsp.handle)
);
